### sv/pcss_pkg.sv
// ============================================================================
// pcss_pkg - shared types and constants for the PNG chunk stream scanner
// Phase and status codes, signature and IEND constants, result bundle.
// ============================================================================
package pcss_pkg;

  localparam int COUNT_BITS = 16;

  localparam logic [31:0] SIG_HI    = 32'h8950_4E47;
  localparam logic [31:0] SIG_LO    = 32'h0D0A_1A0A;
  localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

  localparam logic [3:0]  SIG_BYTES  = 4'd8;
  localparam logic [3:0]  WORD_BYTES = 4'd4;

  localparam logic [30:0] MAX_SIZE_RESET = 31'h7FFF_FFFF;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SIG,
    PH_LEN,
    PH_TYPE,
    PH_PAYLOAD,
    PH_CRC
  } phase_t;

  typedef enum logic [1:0] {
    ST_CHUNK_DONE,
    ST_IEND_DONE,
    ST_BAD_SIG,
    ST_TOO_BIG
  } status_t;

  typedef struct packed {
    logic        valid;
    status_t     status;
    logic [31:0] chunk_type;
    logic [30:0] chunk_length;
    logic [31:0] chunk_crc;
    logic [15:0] chunk_count;
    logic [31:0] total_length;
  } result_t;

endpackage

### sv/png_chunk_stream_scanner.sv
// ============================================================================
// png_chunk_stream_scanner - PNG signature and chunk framing checker
// Walks a PNG byte stream and reports each finished chunk or framing error.
// ============================================================================
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+------------------
//  in      | in_data_byte[7:0], in_start_flag        | in_valid/in_stall
//  out     | out_status, out_chunk_*, out_total_len. | out_valid/out_stall
//  cfg     | cfg_size_limit[30:0]                    | cfg_valid/cfg_ready
//
//  One byte per cycle while out_stall does not hold a result; the input word is
//  registered, then passes the parser logic into the result register.
//  Synchronous active-low reset; the size limit resets to 0x7FFFFFFF.
//  out_stall on a held result freezes the result register and the parser;
//  in_stall rises only while the input register holds a word that cannot move.
//  cfg_ready is always high.
module png_chunk_stream_scanner (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_start_flag,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [31:0] out_chunk_type,
  output logic [30:0] out_chunk_length,
  output logic [31:0] out_chunk_crc,
  output logic [15:0] out_chunk_count,
  output logic [31:0] out_total_length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [30:0] cfg_size_limit
);

  logic              in_valid_r;
  logic [7:0]        in_byte_r;
  logic              in_start_r;
  logic [30:0]       max_size_r;
  logic              adv;
  pcss_pkg::result_t res;
  pcss_pkg::result_t out_r;
  logic              out_valid_r;

  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = in_valid_r && !adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_size_r <= pcss_pkg::MAX_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_size_r <= cfg_size_limit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_byte_r  <= in_data_byte;
      in_start_r <= in_start_flag;
    end
  end

  pcss_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (in_valid_r && adv),
    .data_byte  (in_byte_r),
    .start_flag (in_start_r),
    .size_limit (max_size_r),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= in_valid_r && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid_r && res.valid) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_r.status;
  assign out_chunk_type   = out_r.chunk_type;
  assign out_chunk_length = out_r.chunk_length;
  assign out_chunk_crc    = out_r.chunk_crc;
  assign out_chunk_count  = out_r.chunk_count;
  assign out_total_length = out_r.total_length;

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> in_valid_r && $stable(in_byte_r))
    else $error("input word lost while stalled");

  a_bad_sig_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status == pcss_pkg::ST_BAD_SIG |->
      out_r.total_length == 32'd8 && out_r.chunk_count == 16'd0)
    else $error("bad signature result malformed");

  a_too_big_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status == pcss_pkg::ST_TOO_BIG |->
      out_r.chunk_type == 32'd0 && out_r.chunk_crc == 32'd0)
    else $error("too-big result carries type or crc");

  a_done_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.status == pcss_pkg::ST_CHUNK_DONE ||
                    out_r.status == pcss_pkg::ST_IEND_DONE) |->
      out_r.chunk_count != 16'd0 && out_r.total_length >= 32'd20)
    else $error("chunk result with impossible count or length");

endmodule

### sv/pcss_parser.sv
// ============================================================================
// pcss_parser - chunk framing state machine
// Consumes one byte per step, updates the parser state and presents the
// result (if any) for that byte combinationally.
// ============================================================================
module pcss_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        data_byte,
  input  logic              start_flag,
  input  logic [30:0]       size_limit,
  output pcss_pkg::result_t res
);

  pcss_pkg::phase_t                   phase_r, phase_nxt, ph;
  logic [3:0]                         fidx_r, fidx_nxt;
  logic [31:0]                        len_r, len_nxt;
  logic [31:0]                        type_r, type_nxt;
  logic [31:0]                        crc_r, crc_nxt;
  logic [30:0]                        left_r, left_nxt;
  logic [31:0]                        offs_r, offs_nxt;
  logic [pcss_pkg::COUNT_BITS-1:0]    seen_r, seen_nxt;

  always_comb begin
    phase_nxt = phase_r;
    fidx_nxt  = fidx_r;
    len_nxt   = len_r;
    type_nxt  = type_r;
    crc_nxt   = crc_r;
    left_nxt  = left_r;
    offs_nxt  = offs_r;
    seen_nxt  = seen_r;
    res       = '0;
    ph        = phase_r;

    if (start_flag) begin
      ph        = pcss_pkg::PH_SIG;
      phase_nxt = pcss_pkg::PH_SIG;
      fidx_nxt  = '0;
      len_nxt   = '0;
      type_nxt  = '0;
      crc_nxt   = '0;
      left_nxt  = '0;
      offs_nxt  = '0;
      seen_nxt  = '0;
    end

    if (ph != pcss_pkg::PH_IDLE && offs_nxt != '1) begin
      offs_nxt = offs_nxt + 32'd1;
    end

    case (ph)
      pcss_pkg::PH_IDLE: begin
      end
      pcss_pkg::PH_SIG: begin
        type_nxt = {type_nxt[23:0], len_nxt[31:24]};
        len_nxt  = {len_nxt[23:0], data_byte};
        fidx_nxt = fidx_nxt + 4'd1;
        if (fidx_nxt >= pcss_pkg::SIG_BYTES) begin
          fidx_nxt = '0;
          if (type_nxt != pcss_pkg::SIG_HI || len_nxt != pcss_pkg::SIG_LO) begin
            phase_nxt        = pcss_pkg::PH_IDLE;
            res.valid        = 1'b1;
            res.status       = pcss_pkg::ST_BAD_SIG;
            res.total_length = offs_nxt;
          end else begin
            len_nxt   = '0;
            type_nxt  = '0;
            phase_nxt = pcss_pkg::PH_LEN;
          end
        end
      end
      pcss_pkg::PH_LEN: begin
        len_nxt  = {len_nxt[23:0], data_byte};
        fidx_nxt = fidx_nxt + 4'd1;
        if (fidx_nxt >= pcss_pkg::WORD_BYTES) begin
          fidx_nxt = '0;
          if (len_nxt[31] || len_nxt[30:0] > size_limit) begin
            phase_nxt        = pcss_pkg::PH_IDLE;
            res.valid        = 1'b1;
            res.status       = pcss_pkg::ST_TOO_BIG;
            res.chunk_length = len_nxt[30:0];
            res.chunk_count  = 16'(seen_nxt);
            res.total_length = offs_nxt;
          end else begin
            type_nxt  = '0;
            phase_nxt = pcss_pkg::PH_TYPE;
          end
        end
      end
      pcss_pkg::PH_TYPE: begin
        type_nxt = {type_nxt[23:0], data_byte};
        fidx_nxt = fidx_nxt + 4'd1;
        if (fidx_nxt >= pcss_pkg::WORD_BYTES) begin
          fidx_nxt  = '0;
          crc_nxt   = '0;
          left_nxt  = len_nxt[30:0];
          phase_nxt = (len_nxt[30:0] != '0) ? pcss_pkg::PH_PAYLOAD : pcss_pkg::PH_CRC;
        end
      end
      pcss_pkg::PH_PAYLOAD: begin
        left_nxt = left_nxt - 31'd1;
        if (left_nxt == '0) begin
          phase_nxt = pcss_pkg::PH_CRC;
        end
      end
      pcss_pkg::PH_CRC: begin
        crc_nxt  = {crc_nxt[23:0], data_byte};
        fidx_nxt = fidx_nxt + 4'd1;
        if (fidx_nxt >= pcss_pkg::WORD_BYTES) begin
          fidx_nxt = '0;
          if (seen_nxt != '1) begin
            seen_nxt = seen_nxt + {{(pcss_pkg::COUNT_BITS-1){1'b0}}, 1'b1};
          end
          res.valid        = 1'b1;
          res.status       = (type_nxt == pcss_pkg::TYPE_IEND) ?
                             pcss_pkg::ST_IEND_DONE : pcss_pkg::ST_CHUNK_DONE;
          res.chunk_type   = type_nxt;
          res.chunk_length = len_nxt[30:0];
          res.chunk_crc    = crc_nxt;
          res.chunk_count  = 16'(seen_nxt);
          res.total_length = offs_nxt;
          if (type_nxt == pcss_pkg::TYPE_IEND) begin
            phase_nxt = pcss_pkg::PH_IDLE;
          end else begin
            len_nxt   = '0;
            phase_nxt = pcss_pkg::PH_LEN;
          end
        end
      end
      default: begin
        phase_nxt = pcss_pkg::PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= pcss_pkg::PH_IDLE;
      fidx_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      fidx_r  <= fidx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      len_r  <= len_nxt;
      type_r <= type_nxt;
      crc_r  <= crc_nxt;
      left_r <= left_nxt;
      offs_r <= offs_nxt;
      seen_r <= seen_nxt;
    end
  end

endmodule
